FILE: rtl/sct_pkg.sv
// Shared types and constants for the sorted contact table.
`timescale 1ns / 1ps
package sct_pkg;

  localparam int OWN_W    = 12;
  localparam int PSEG_W   = 12;
  localparam int CHROM_W  = 5;
  localparam int STATUS_W = 3;
  localparam int SLOT_W   = 8;

  typedef enum logic [STATUS_W-1:0] {
    ST_NEW_KEY    = 3'd0,
    ST_LINK_ADDED = 3'd1,
    ST_DUPLICATE  = 3'd2,
    ST_TABLE_FULL = 3'd3,
    ST_LIST_FULL  = 3'd4
  } status_t;

  typedef struct packed {
    logic load;
    logic pos_inc;
    logic rd_key;
    logic rd_cnt;
    logic set_shift;
    logic rd_shift;
    logic wr_shift;
    logic wr_new;
    logic rd_link;
    logic idx_inc;
    logic wr_link;
    logic load_out;
  } sct_cmd_t;

  typedef struct packed {
    logic pos_at_n;
    logic key_lt;
    logic key_eq;
    logic n_full;
    logic j_at_pos;
    logic idx_at_cnt;
    logic cnt_full;
    logic link_eq;
    logic out_busy;
  } sct_stat_t;

endpackage

FILE: rtl/sct_if.sv
// Valid/ready channel interfaces for contact and result words.
`timescale 1ns / 1ps
interface sct_contact_if;
  import sct_pkg::*;
  logic                 valid;
  logic                 ready;
  logic [OWN_W-1:0]     own_segment;
  logic [PSEG_W-1:0]    partner_segment;
  logic [CHROM_W-1:0]   partner_chrom;
  modport source (output valid, own_segment, partner_segment, partner_chrom, input ready);
  modport sink   (input valid, own_segment, partner_segment, partner_chrom, output ready);
endinterface

interface sct_result_if;
  import sct_pkg::*;
  logic                valid;
  logic                ready;
  logic [STATUS_W-1:0] status;
  logic [SLOT_W-1:0]   slot;
  modport source (output valid, status, slot, input ready);
  modport sink   (input valid, status, slot, output ready);
endinterface

FILE: rtl/sct_datapath.sv
// Datapath: key, count and link memories, scan counters and output register.
`timescale 1ns / 1ps
module sct_datapath #(
  parameter int MAX_KEYS  = 256,
  parameter int MAX_LINKS = 8,
  parameter int SEG_BITS  = 12
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic [sct_pkg::OWN_W-1:0]     own_segment,
  input  logic [sct_pkg::PSEG_W-1:0]    partner_segment,
  input  logic [sct_pkg::CHROM_W-1:0]   partner_chrom,
  input  sct_pkg::sct_cmd_t             cmd,
  input  sct_pkg::status_t              code,
  output sct_pkg::sct_stat_t            stat,
  input  logic                          out_ready,
  output logic                          out_valid,
  output logic [sct_pkg::STATUS_W-1:0]  out_status,
  output logic [sct_pkg::SLOT_W-1:0]    out_slot
);
  import sct_pkg::*;

  localparam int IDX_W   = $clog2(MAX_KEYS);
  localparam int CNT_W   = $clog2(MAX_KEYS + 1);
  localparam int LCNT_W  = $clog2(MAX_LINKS + 1);
  localparam int LADDR_W = $clog2(MAX_KEYS * MAX_LINKS);
  localparam int LINK_W  = CHROM_W + SEG_BITS;
  localparam int ENT_W   = IDX_W + SEG_BITS;

  // key entry: {row pointer, key}; link lists live in rows that never move
  logic [ENT_W-1:0]  key_mem  [MAX_KEYS];
  logic [LCNT_W-1:0] cnt_mem  [MAX_KEYS];
  logic [LINK_W-1:0] link_mem [MAX_KEYS*MAX_LINKS];

  logic [SEG_BITS-1:0] key;
  logic [LINK_W-1:0]   link;
  logic [CNT_W-1:0]    n;
  logic [CNT_W-1:0]    pos;
  logic [CNT_W-1:0]    j;
  logic [IDX_W-1:0]    ptr;
  logic [LCNT_W-1:0]   idx;
  logic [ENT_W-1:0]    key_rd;
  logic [LCNT_W-1:0]   cnt_rd;
  logic [LINK_W-1:0]   link_rd;
  logic [IDX_W-1:0]    key_raddr;
  logic [LCNT_W-1:0]   lidx;
  logic [LADDR_W-1:0]  laddr;
  logic [SEG_BITS-1:0] rd_key_val;

  assign rd_key_val = key_rd[SEG_BITS-1:0];
  assign key_raddr  = cmd.rd_shift ? IDX_W'(j - CNT_W'(1)) : pos[IDX_W-1:0];
  assign lidx       = cmd.wr_link ? cnt_rd : idx;
  assign laddr      = LADDR_W'(LADDR_W'(ptr) * LADDR_W'(MAX_LINKS) + LADDR_W'(lidx));

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      key  <= SEG_BITS'(own_segment);
      link <= {partner_chrom, SEG_BITS'(partner_segment)};
      pos  <= '0;
      idx  <= '0;
    end
    if (cmd.pos_inc) pos <= pos + CNT_W'(1);
    if (cmd.idx_inc) idx <= idx + LCNT_W'(1);
    if (cmd.set_shift) j <= n;
    if (cmd.wr_shift) j <= j - CNT_W'(1);
    if (cmd.rd_cnt) ptr <= key_rd[ENT_W-1:SEG_BITS];
    if (cmd.rd_key || cmd.rd_shift) key_rd <= key_mem[key_raddr];
    if (cmd.wr_shift) key_mem[j[IDX_W-1:0]] <= key_rd;
    if (cmd.wr_new) begin
      key_mem[pos[IDX_W-1:0]] <= {n[IDX_W-1:0], key};
      cnt_mem[n[IDX_W-1:0]]   <= LCNT_W'(1);
      link_mem[LADDR_W'(LADDR_W'(n[IDX_W-1:0]) * LADDR_W'(MAX_LINKS))] <= link;
    end
    if (cmd.rd_cnt) cnt_rd <= cnt_mem[key_rd[ENT_W-1:SEG_BITS]];
    if (cmd.rd_link) link_rd <= link_mem[laddr];
    if (cmd.wr_link) begin
      link_mem[laddr] <= link;
      cnt_mem[ptr]    <= cnt_rd + LCNT_W'(1);
    end
    if (cmd.load_out) begin
      out_status <= code;
      out_slot   <= (code == ST_TABLE_FULL) ? '0 : SLOT_W'(pos);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      n         <= '0;
      out_valid <= 1'b0;
    end else begin
      if (cmd.wr_new) n <= n + CNT_W'(1);
      if (cmd.load_out) out_valid <= 1'b1;
      else if (out_ready) out_valid <= 1'b0;
    end
  end

  always_comb begin
    stat.pos_at_n   = (pos == n);
    stat.key_lt     = (rd_key_val < key);
    stat.key_eq     = (rd_key_val == key);
    stat.n_full     = (n == CNT_W'(MAX_KEYS));
    stat.j_at_pos   = (j == pos);
    stat.idx_at_cnt = (idx == cnt_rd);
    stat.cnt_full   = (cnt_rd == LCNT_W'(MAX_LINKS));
    stat.link_eq    = (link_rd == link);
    stat.out_busy   = out_valid && !out_ready;
  end

endmodule

FILE: rtl/sct_ctrl.sv
// Controller: sequences search, shift, link scan and result hand-off.
`timescale 1ns / 1ps
module sct_ctrl (
  input  logic                clk,
  input  logic                rst,
  input  logic                in_valid,
  output logic                in_ready,
  input  sct_pkg::sct_stat_t  stat,
  output sct_pkg::sct_cmd_t   cmd,
  output sct_pkg::status_t    code
);
  import sct_pkg::*;

  typedef enum logic [3:0] {
    S_IDLE, S_KRD, S_KCMP, S_MISS, S_SHRD, S_SHWR, S_CNT, S_LRD, S_LCMP, S_OUT
  } state_t;

  state_t state;
  state_t state_next;
  status_t code_next;

  assign in_ready = (state == S_IDLE);

  always_comb begin
    cmd        = '0;
    state_next = state;
    code_next  = code;
    case (state)
      S_IDLE: begin
        if (in_valid) begin
          cmd.load   = 1'b1;
          state_next = S_KRD;
        end
      end
      S_KRD: begin
        if (stat.pos_at_n) state_next = S_MISS;
        else begin
          cmd.rd_key = 1'b1;
          state_next = S_KCMP;
        end
      end
      S_KCMP: begin
        if (stat.key_lt) begin
          cmd.pos_inc = 1'b1;
          state_next  = S_KRD;
        end else if (stat.key_eq) begin
          cmd.rd_cnt = 1'b1;
          state_next = S_CNT;
        end else begin
          state_next = S_MISS;
        end
      end
      S_MISS: begin
        if (stat.n_full) begin
          code_next  = ST_TABLE_FULL;
          state_next = S_OUT;
        end else begin
          cmd.set_shift = 1'b1;
          state_next    = S_SHRD;
        end
      end
      S_SHRD: begin
        if (stat.j_at_pos) begin
          cmd.wr_new = 1'b1;
          code_next  = ST_NEW_KEY;
          state_next = S_OUT;
        end else begin
          cmd.rd_shift = 1'b1;
          state_next   = S_SHWR;
        end
      end
      S_SHWR: begin
        cmd.wr_shift = 1'b1;
        state_next   = S_SHRD;
      end
      S_CNT: state_next = S_LRD;
      S_LRD: begin
        if (stat.idx_at_cnt) begin
          if (stat.cnt_full) code_next = ST_LIST_FULL;
          else begin
            cmd.wr_link = 1'b1;
            code_next   = ST_LINK_ADDED;
          end
          state_next = S_OUT;
        end else begin
          cmd.rd_link = 1'b1;
          state_next  = S_LCMP;
        end
      end
      S_LCMP: begin
        if (stat.link_eq) begin
          code_next  = ST_DUPLICATE;
          state_next = S_OUT;
        end else begin
          cmd.idx_inc = 1'b1;
          state_next  = S_LRD;
        end
      end
      S_OUT: begin
        // hold until the output register frees up
        if (!stat.out_busy) begin
          cmd.load_out = 1'b1;
          state_next   = S_IDLE;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      code  <= ST_NEW_KEY;
    end else begin
      state <= state_next;
      code  <= code_next;
    end
  end

endmodule

FILE: rtl/sorted_contact_table_insert.sv
// Top level of the sorted contact table insert block.
//
//  channel   dir  word                                            
//  contact   in   own_segment, partner_segment, partner_chrom     
//  result    out  status, slot                                    
//
// A contact's search reads the held keys in sorted order until it meets its key, a
// larger key or the end. A held key's links are then scanned, stopping early on a
// duplicate; a new key, when the table has room, instead moves every key at or past
// its position up one entry. The key memory's single read port serves both loops.
// Synchronous reset clears the key count and the controller; memories need
// no clearing pass. A contact is taken while the last result still waits;
// the block stalls before loading the next result until that one is taken.
`timescale 1ns / 1ps
module sorted_contact_table_insert #(
  parameter int MAX_KEYS  = 256,
  parameter int MAX_LINKS = 8,
  parameter int SEG_BITS  = 12
) (
  input logic         clk,
  input logic         rst,
  sct_contact_if.sink contact,
  sct_result_if.source result
);
  import sct_pkg::*;

  sct_cmd_t  cmd;
  sct_stat_t stat;
  status_t   code;

  sct_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (contact.valid),
    .in_ready (contact.ready),
    .stat     (stat),
    .cmd      (cmd),
    .code     (code)
  );

  sct_datapath #(
    .MAX_KEYS  (MAX_KEYS),
    .MAX_LINKS (MAX_LINKS),
    .SEG_BITS  (SEG_BITS)
  ) u_dp (
    .clk             (clk),
    .rst             (rst),
    .own_segment     (contact.own_segment),
    .partner_segment (contact.partner_segment),
    .partner_chrom   (contact.partner_chrom),
    .cmd             (cmd),
    .code            (code),
    .stat            (stat),
    .out_ready       (result.ready),
    .out_valid       (result.valid),
    .out_status      (result.status),
    .out_slot        (result.slot)
  );

endmodule
